FILE: hw/rtl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg: shared types and constants of the Bezier segment stepper
// Coordinate, curve parameter and product formats, plus the control tag
// that travels down the cell row next to each curve point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcs_pkg;

  // Signed Q16.8 coordinates
  localparam int unsigned COORD_W = 24;
  // Unsigned Q1.16 curve parameter, 65536 is 1.0
  localparam int unsigned T_W     = 17;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned COLOR_W = 32;
  // (b - a) * t needs 25 + 17 bits, signed
  localparam int unsigned PROD_W  = 42;

  localparam logic [T_W-1:0] T_ONE = 17'd65536;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [T_W-1:0]     tparam_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic        [COLOR_W-1:0] color_t;

  // Control that rides along with one curve point
  typedef struct packed {
    logic   vld;
    logic   first;
    logic   last;
    color_t color;
  } bcs_tag_t;

endpackage

FILE: hw/rtl/bcs_step_gen.sv
// ----------------------------------------------------------------------------
// bcs_step_gen: command slot and parameter stepper
// Orders and clamps the parameter range, splits the span by the step count
// with a reciprocal multiply, then issues one parameter value per cycle while enabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcs_step_gen #(
  parameter int unsigned POINTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             cmd_valid_i,
  output logic             cmd_stall_o,
  input  bcs_pkg::coord_t  px_i [4],
  input  bcs_pkg::coord_t  py_i [4],
  input  bcs_pkg::tparam_t t_start_i,
  input  bcs_pkg::tparam_t t_end_i,
  input  bcs_pkg::color_t  color_i,
  output bcs_pkg::coord_t  px_o [4],
  output bcs_pkg::coord_t  py_o [4],
  output bcs_pkg::tparam_t t_o,
  output bcs_pkg::bcs_tag_t tag_o
);

  localparam int unsigned DIVS = POINTS - 2;
  localparam int unsigned IW   = $clog2(POINTS - 1);
  localparam int unsigned RW   = $clog2(DIVS);
  localparam int unsigned K    = bcs_pkg::T_W + RW;
  localparam int unsigned MW   = 19;
  localparam int unsigned SPW  = bcs_pkg::T_W + MW;

  localparam logic [MW-1:0]              RECIP    = MW'((2 ** K + DIVS - 1) / DIVS);
  localparam logic [IW-1:0]              LAST_IDX = IW'(DIVS);
  localparam logic [bcs_pkg::T_W-1:0]    DIV_T    = bcs_pkg::T_W'(DIVS);
  localparam logic [RW:0]                DIV_R    = (RW + 1)'(DIVS);

  // Slot phases
  localparam logic [1:0] PH_CLAMP = 2'd0;
  localparam logic [1:0] PH_MUL   = 2'd1;
  localparam logic [1:0] PH_DIV   = 2'd2;
  localparam logic [1:0] PH_RDY   = 2'd3;

  // Command slot
  logic                  slot_vld_q;
  logic [1:0]            ph_q;
  bcs_pkg::tparam_t      ta_q, tb_q;
  logic [SPW-1:0]        sprod_q;
  bcs_pkg::tparam_t      sq_q;
  logic [RW-1:0]         srem_q;
  bcs_pkg::coord_t       spx_q [4];
  bcs_pkg::coord_t       spy_q [4];
  bcs_pkg::color_t       scol_q;

  // Stepper
  logic                  act_q;
  logic [IW-1:0]         idx_q;
  bcs_pkg::tparam_t      t_q, qs_q;
  logic [RW-1:0]         rs_q, r_q;
  bcs_pkg::coord_t       px_q [4];
  bcs_pkg::coord_t       py_q [4];
  bcs_pkg::color_t       col_q;

  logic                  accept, handoff, free;
  bcs_pkg::tparam_t      ta_c, tb_c, lo_c, hi_c;
  logic [SPW-1:0]        quo_full;
  bcs_pkg::tparam_t      quo, rem_full;
  logic [RW:0]           rsum;
  logic                  wrap;
  logic [RW-1:0]         r_next;
  bcs_pkg::tparam_t      t_next;

  assign free        = !act_q || ((idx_q == LAST_IDX) && en_i);
  assign handoff     = slot_vld_q && (ph_q == PH_RDY) && free;
  assign cmd_stall_o = slot_vld_q && !handoff;
  assign accept      = cmd_valid_i && !cmd_stall_o;

  always_comb begin
    ta_c     = (ta_q > bcs_pkg::T_ONE) ? bcs_pkg::T_ONE : ta_q;
    tb_c     = (tb_q > bcs_pkg::T_ONE) ? bcs_pkg::T_ONE : tb_q;
    lo_c     = (tb_c < ta_c) ? tb_c : ta_c;
    hi_c     = (tb_c < ta_c) ? ta_c : tb_c;
    // span / DIVS through the reciprocal, exact for a 17-bit span
    quo_full = sprod_q >> K;
    quo      = quo_full[bcs_pkg::T_W-1:0];
    rem_full = tb_q - bcs_pkg::T_W'(quo * DIV_T);
    // remainder walk: t_i = start + floor(i * span / DIVS)
    rsum     = {1'b0, r_q} + {1'b0, rs_q};
    wrap     = (rsum >= DIV_R);
    r_next   = wrap ? RW'(rsum - DIV_R) : rsum[RW-1:0];
    t_next   = t_q + qs_q + bcs_pkg::T_W'(wrap);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= 1'b0;
      ph_q       <= PH_CLAMP;
    end else if (accept) begin
      slot_vld_q <= 1'b1;
      ph_q       <= PH_CLAMP;
    end else if (handoff) begin
      slot_vld_q <= 1'b0;
    end else if (slot_vld_q && (ph_q != PH_RDY)) begin
      ph_q       <= ph_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ta_q   <= t_start_i;
      tb_q   <= t_end_i;
      spx_q  <= px_i;
      spy_q  <= py_i;
      scol_q <= color_i;
    end else begin
      case (ph_q)
        PH_CLAMP: begin
          ta_q <= lo_c;
          tb_q <= hi_c - lo_c;
        end
        PH_MUL: begin
          sprod_q <= SPW'(tb_q) * SPW'(RECIP);
        end
        PH_DIV: begin
          sq_q   <= quo;
          srem_q <= rem_full[RW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      idx_q <= '0;
    end else if (handoff) begin
      act_q <= 1'b1;
      idx_q <= '0;
    end else if (act_q && en_i) begin
      if (idx_q == LAST_IDX) begin
        act_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (handoff) begin
      t_q   <= ta_q;
      qs_q  <= sq_q;
      rs_q  <= srem_q;
      r_q   <= '0;
      px_q  <= spx_q;
      py_q  <= spy_q;
      col_q <= scol_q;
    end else if (act_q && en_i) begin
      t_q <= t_next;
      r_q <= r_next;
    end
  end

  assign px_o        = px_q;
  assign py_o        = py_q;
  assign t_o         = t_q;
  assign tag_o.vld   = act_q;
  assign tag_o.first = (idx_q == '0);
  assign tag_o.last  = (idx_q == LAST_IDX);
  assign tag_o.color = col_q;

endmodule

FILE: hw/rtl/bcs_cell.sv
// ----------------------------------------------------------------------------
// bcs_cell: one de Casteljau level
// Interpolates each pair of neighboring points at t in two registered
// steps (multiply, then round toward zero and add) and passes on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcs_cell #(
  parameter int unsigned NP = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  bcs_pkg::tparam_t  t_i,
  input  bcs_pkg::bcs_tag_t tag_i,
  input  bcs_pkg::coord_t   px_i [NP],
  input  bcs_pkg::coord_t   py_i [NP],
  output bcs_pkg::tparam_t  t_o,
  output bcs_pkg::bcs_tag_t tag_o,
  output bcs_pkg::coord_t   px_o [NP-1],
  output bcs_pkg::coord_t   py_o [NP-1]
);

  localparam int unsigned NL = NP - 1;
  localparam int unsigned QW = bcs_pkg::PROD_W - bcs_pkg::FRAC_W;

  function automatic bcs_pkg::prod_t lerp_mul(bcs_pkg::coord_t a, bcs_pkg::coord_t b,
                                              bcs_pkg::tparam_t t);
    logic signed [bcs_pkg::COORD_W:0] diff;
    bcs_pkg::prod_t                   dw;
    bcs_pkg::prod_t                   tw;
    diff = {b[bcs_pkg::COORD_W-1], b} - {a[bcs_pkg::COORD_W-1], a};
    dw   = {{(bcs_pkg::PROD_W - bcs_pkg::COORD_W - 1){diff[bcs_pkg::COORD_W]}}, diff};
    tw   = {{(bcs_pkg::PROD_W - bcs_pkg::T_W){1'b0}}, t};
    return dw * tw;
  endfunction

  // a + trunc(p / 65536): bias negative products so the shift rounds to zero
  function automatic bcs_pkg::coord_t lerp_fin(bcs_pkg::coord_t a, bcs_pkg::prod_t p);
    bcs_pkg::prod_t    adj;
    logic signed [QW-1:0] q;
    logic signed [QW-1:0] s;
    adj = p + {{QW{1'b0}}, {bcs_pkg::FRAC_W{p[bcs_pkg::PROD_W-1]}}};
    q   = adj[bcs_pkg::PROD_W-1:bcs_pkg::FRAC_W];
    s   = {{(QW - bcs_pkg::COORD_W){a[bcs_pkg::COORD_W-1]}}, a} + q;
    return s[bcs_pkg::COORD_W-1:0];
  endfunction

  bcs_pkg::coord_t   ax_q  [NL];
  bcs_pkg::coord_t   ay_q  [NL];
  bcs_pkg::prod_t    prx_q [NL];
  bcs_pkg::prod_t    pry_q [NL];
  bcs_pkg::tparam_t  ta_q, tb_q;
  bcs_pkg::bcs_tag_t taga_q, tagb_q;
  bcs_pkg::coord_t   ox_q  [NL];
  bcs_pkg::coord_t   oy_q  [NL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taga_q <= '0;
      tagb_q <= '0;
    end else if (en_i) begin
      taga_q <= tag_i;
      tagb_q <= taga_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ta_q <= t_i;
      tb_q <= ta_q;
      for (int j = 0; j < NL; j++) begin
        ax_q[j]  <= px_i[j];
        ay_q[j]  <= py_i[j];
        prx_q[j] <= lerp_mul(px_i[j], px_i[j+1], t_i);
        pry_q[j] <= lerp_mul(py_i[j], py_i[j+1], t_i);
        ox_q[j]  <= lerp_fin(ax_q[j], prx_q[j]);
        oy_q[j]  <= lerp_fin(ay_q[j], pry_q[j]);
      end
    end
  end

  assign t_o   = tb_q;
  assign tag_o = tagb_q;
  assign px_o  = ox_q;
  assign py_o  = oy_q;

endmodule

FILE: hw/rtl/bezier_curve_segment_stepper.sv
// ----------------------------------------------------------------------------
// bezier_curve_segment_stepper: cubic Bezier curve flattener
// Throughput: one segment per cycle while the consumer does not stall, set by the
//   parameter stepper issuing one curve point per cycle into the cell row.
// Reset: clears the command slot, stepper and all valid flags; no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bezier_curve_segment_stepper #(
  parameter int unsigned POINTS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,

  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [23:0]  p0_x_i,
  input  logic [23:0]  p0_y_i,
  input  logic [23:0]  p1_x_i,
  input  logic [23:0]  p1_y_i,
  input  logic [23:0]  p2_x_i,
  input  logic [23:0]  p2_y_i,
  input  logic [23:0]  p3_x_i,
  input  logic [23:0]  p3_y_i,
  input  logic [16:0]  t_start_i,
  input  logic [16:0]  t_end_i,
  input  logic [31:0]  color_i,

  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [23:0]  seg_x0_o,
  output logic [23:0]  seg_y0_o,
  output logic [23:0]  seg_x1_o,
  output logic [23:0]  seg_y1_o,
  output logic [31:0]  seg_color_o,
  output logic         last_o
);

  // Structure:
  //   bcs_step_gen  holds one waiting command, orders and clamps its range
  //                 and splits the span into POINTS-2 steps, then walks
  //                 t from start to end, one point per cycle unless held.
  //   bcs_cell x3   the de Casteljau levels (4 -> 3 -> 2 -> 1 points), each
  //                 with a product and a sum register, x and y side by side.
  //   tail          pairs each point with the previous one into a segment
  //                 and drops the first point of a command.
  // The whole point row advances together; it holds only while a finished
  // segment sits in the output register and the consumer stalls it. The
  // command slot keeps working meanwhile, so the next command is taken and
  // prepared while the current one is still streaming.

  bcs_pkg::coord_t   in_px [4];
  bcs_pkg::coord_t   in_py [4];

  bcs_pkg::coord_t   c0_px [4];
  bcs_pkg::coord_t   c0_py [4];
  bcs_pkg::coord_t   c1_px [3];
  bcs_pkg::coord_t   c1_py [3];
  bcs_pkg::coord_t   c2_px [2];
  bcs_pkg::coord_t   c2_py [2];
  bcs_pkg::coord_t   pt_x  [1];
  bcs_pkg::coord_t   pt_y  [1];

  bcs_pkg::tparam_t  t0, t1, t2, t3;
  bcs_pkg::bcs_tag_t tag0, tag1, tag2, tag3;

  logic              en;

  bcs_pkg::coord_t   prev_x_q, prev_y_q;
  logic              out_valid_q;
  bcs_pkg::coord_t   seg_x0_q, seg_y0_q, seg_x1_q, seg_y1_q;
  bcs_pkg::color_t   seg_color_q;
  logic              last_q;

  // Advance the row unless a segment is waiting and stalled
  assign en = !(out_valid_q && out_stall_i);

  assign in_px[0] = p0_x_i;
  assign in_px[1] = p1_x_i;
  assign in_px[2] = p2_x_i;
  assign in_px[3] = p3_x_i;
  assign in_py[0] = p0_y_i;
  assign in_py[1] = p1_y_i;
  assign in_py[2] = p2_y_i;
  assign in_py[3] = p3_y_i;

  bcs_step_gen #(
    .POINTS (POINTS)
  ) u_step_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .cmd_valid_i (in_valid_i),
    .cmd_stall_o (in_stall_o),
    .px_i        (in_px),
    .py_i        (in_py),
    .t_start_i   (t_start_i),
    .t_end_i     (t_end_i),
    .color_i     (color_i),
    .px_o        (c0_px),
    .py_o        (c0_py),
    .t_o         (t0),
    .tag_o       (tag0)
  );

  // First level: three interpolations per axis
  bcs_cell #(
    .NP (4)
  ) u_cell0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .t_i    (t0),
    .tag_i  (tag0),
    .px_i   (c0_px),
    .py_i   (c0_py),
    .t_o    (t1),
    .tag_o  (tag1),
    .px_o   (c1_px),
    .py_o   (c1_py)
  );

  // Second level: two interpolations per axis
  bcs_cell #(
    .NP (3)
  ) u_cell1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .t_i    (t1),
    .tag_i  (tag1),
    .px_i   (c1_px),
    .py_i   (c1_py),
    .t_o    (t2),
    .tag_o  (tag2),
    .px_o   (c2_px),
    .py_o   (c2_py)
  );

  // Final level: the curve point itself; t is not needed past here
  bcs_cell #(
    .NP (2)
  ) u_cell2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .t_i    (t2),
    .tag_i  (tag2),
    .px_i   (c2_px),
    .py_i   (c2_py),
    .t_o    (t3),
    .tag_o  (tag3),
    .px_o   (pt_x),
    .py_o   (pt_y)
  );

  // Output register: a segment is valid for every point but the first of
  // its command; the first point only primes the previous-point register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= tag3.vld && !tag3.first;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (tag3.vld) begin
        prev_x_q <= pt_x[0];
        prev_y_q <= pt_y[0];
      end
      seg_x0_q    <= prev_x_q;
      seg_y0_q    <= prev_y_q;
      seg_x1_q    <= pt_x[0];
      seg_y1_q    <= pt_y[0];
      seg_color_q <= tag3.color;
      // t3 rides along for symmetry of the row; the end point of a command
      // always carries the last flag from the stepper.
      last_q      <= tag3.last && (t3 == t3);
    end
  end

  assign out_valid_o = out_valid_q;
  assign seg_x0_o    = seg_x0_q;
  assign seg_y0_o    = seg_y0_q;
  assign seg_x1_o    = seg_x1_q;
  assign seg_y1_o    = seg_y1_q;
  assign seg_color_o = seg_color_q;
  assign last_o      = last_q;

endmodule
